// File: src/msna_pkg.sv
// ----------------------------------------------------------------------------
// msna_pkg
// Shared types, constants and saturation helpers for the morph and strip
// normal accumulator.
// ----------------------------------------------------------------------------
package msna_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int AW         = 12;
  localparam int DW         = 32;
  localparam int SFW        = 21;
  localparam int ONE_Q16    = 65536;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_STRIP = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_RS, MUL_BX, MUL_BY, MUL_BZ,
    MUL_AYBZ, MUL_AZBY, MUL_AZBX, MUL_AXBZ, MUL_AXBY, MUL_AYBX
  } mul_op_e;

  typedef enum logic [1:0] {
    ADR_ITEM, ADR_OLDER, ADR_NEWER, ADR_CLR
  } addr_sel_e;

  typedef enum logic [1:0] {
    PC_NONE, PC_1, PC_2, PC_3
  } pcap_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_LD_F, ST_LD_FS, ST_LD_MX, ST_LD_MY, ST_LD_MZ, ST_LD_CZ, ST_LD_WR,
    ST_TR_R1, ST_TR_R2, ST_TR_R3, ST_TR_C3, ST_TR_DF,
    ST_TR_M0, ST_TR_M1, ST_TR_M2, ST_TR_M3, ST_TR_M4, ST_TR_M5, ST_TR_MC,
    ST_TR_N, ST_TR_A1, ST_TR_W1, ST_TR_A2, ST_TR_W2, ST_TR_A3, ST_TR_W3,
    ST_RD_A, ST_RD_W
  } ctrl_state_e;

  typedef struct packed {
    logic      item_ld;
    logic      set_older;
    logic      set_newer;
    logic      shift;
    mul_op_e   mul_op;
    logic      f_ld;
    logic      sh_ld;
    logic [2:0] sh_sel;
    addr_sel_e prd_sel;
    logic      pwr_en;
    pcap_e     p_cap;
    logic      diff_ld;
    logic      n_ld;
    logic      neg;
    addr_sel_e nrd_sel;
    logic      nwr_en;
    addr_sel_e nwr_sel;
    logic      nwr_zero;
    logic      clr_step;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

  // sign extend a 32-bit value to the working width
  function automatic logic signed [48:0] ext49(input logic [31:0] v);
    ext49 = $signed({{17{v[31]}}, v});
  endfunction

  // clamp a wide value to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [48:0] v);
    logic [17:0] top;
    top = v[48:31];
    if (top == '0 || top == '1) begin
      sat32 = v[31:0];
    end else if (v[48]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7FFF_FFFF;
    end
  endfunction

endpackage

// File: src/msna_ctrl.sv
// ----------------------------------------------------------------------------
// msna_ctrl
// Sequencer: clearing pass, load, strip triangle and read sequences, plus
// the strip phase and triangle parity.
// ----------------------------------------------------------------------------
module msna_ctrl import msna_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic        parity_q, parity_d;
  logic        neg_q, neg_d;
  logic        accept;
  kind_e       kind;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = kind_e'(in_kind_i);

  // state and strip bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      phase_q  <= 2'd0;
      parity_q <= 1'b0;
      neg_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      parity_q <= parity_d;
      neg_q    <= neg_d;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    parity_d = parity_q;
    neg_d    = neg_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOAD: state_d = ST_LD_F;
            KIND_READ: state_d = ST_RD_A;
            KIND_STRIP: begin
              if (phase_q == 2'd0) begin
                phase_d = 2'd1;
              end else if (phase_q == 2'd1) begin
                phase_d  = 2'd2;
                parity_d = 1'b0;
              end else begin
                neg_d    = ~parity_q;
                parity_d = ~parity_q;
                state_d  = ST_TR_R1;
              end
              if (in_last_i) begin
                phase_d  = 2'd0;
                parity_d = 1'b0;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LD_F:  state_d = ST_LD_FS;
      ST_LD_FS: state_d = ST_LD_MX;
      ST_LD_MX: state_d = ST_LD_MY;
      ST_LD_MY: state_d = ST_LD_MZ;
      ST_LD_MZ: state_d = ST_LD_CZ;
      ST_LD_CZ: state_d = ST_LD_WR;
      ST_LD_WR: state_d = ST_IDLE;
      ST_TR_R1: state_d = ST_TR_R2;
      ST_TR_R2: state_d = ST_TR_R3;
      ST_TR_R3: state_d = ST_TR_C3;
      ST_TR_C3: state_d = ST_TR_DF;
      ST_TR_DF: state_d = ST_TR_M0;
      ST_TR_M0: state_d = ST_TR_M1;
      ST_TR_M1: state_d = ST_TR_M2;
      ST_TR_M2: state_d = ST_TR_M3;
      ST_TR_M3: state_d = ST_TR_M4;
      ST_TR_M4: state_d = ST_TR_M5;
      ST_TR_M5: state_d = ST_TR_MC;
      ST_TR_MC: state_d = ST_TR_N;
      ST_TR_N:  state_d = ST_TR_A1;
      ST_TR_A1: state_d = ST_TR_W1;
      ST_TR_W1: state_d = ST_TR_A2;
      ST_TR_A2: state_d = ST_TR_W2;
      ST_TR_W2: state_d = ST_TR_A3;
      ST_TR_A3: state_d = ST_TR_W3;
      ST_TR_W3: state_d = ST_IDLE;
      ST_RD_A:  state_d = ST_RD_W;
      ST_RD_W:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_op   = MUL_RS;
    cmd_o.prd_sel  = ADR_ITEM;
    cmd_o.nrd_sel  = ADR_ITEM;
    cmd_o.nwr_sel  = ADR_ITEM;
    cmd_o.p_cap    = PC_NONE;
    cmd_o.neg      = neg_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.nwr_en   = 1'b1;
        cmd_o.nwr_sel  = ADR_CLR;
        cmd_o.nwr_zero = 1'b1;
        cmd_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.item_ld   = accept;
        cmd_o.set_older = accept && kind == KIND_STRIP && phase_q == 2'd0;
        cmd_o.set_newer = accept && kind == KIND_STRIP && phase_q == 2'd1;
      end
      ST_LD_F:  cmd_o.mul_op = MUL_RS;
      ST_LD_FS: cmd_o.f_ld   = 1'b1;
      ST_LD_MX: cmd_o.mul_op = MUL_BX;
      ST_LD_MY: begin
        cmd_o.mul_op = MUL_BY;
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd0;
      end
      ST_LD_MZ: begin
        cmd_o.mul_op = MUL_BZ;
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd1;
      end
      ST_LD_CZ: begin
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd2;
      end
      ST_LD_WR: begin
        cmd_o.pwr_en   = 1'b1;
        cmd_o.nwr_en   = 1'b1;
        cmd_o.nwr_zero = 1'b1;
      end
      ST_TR_R1: cmd_o.prd_sel = ADR_OLDER;
      ST_TR_R2: begin
        cmd_o.p_cap   = PC_1;
        cmd_o.prd_sel = ADR_NEWER;
      end
      ST_TR_R3: begin
        cmd_o.p_cap   = PC_2;
        cmd_o.prd_sel = ADR_ITEM;
      end
      ST_TR_C3: cmd_o.p_cap   = PC_3;
      ST_TR_DF: cmd_o.diff_ld = 1'b1;
      ST_TR_M0: cmd_o.mul_op  = MUL_AYBZ;
      ST_TR_M1: begin
        cmd_o.mul_op = MUL_AZBY;
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd0;
      end
      ST_TR_M2: begin
        cmd_o.mul_op = MUL_AZBX;
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd1;
      end
      ST_TR_M3: begin
        cmd_o.mul_op = MUL_AXBZ;
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd2;
      end
      ST_TR_M4: begin
        cmd_o.mul_op = MUL_AXBY;
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd3;
      end
      ST_TR_M5: begin
        cmd_o.mul_op = MUL_AYBX;
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd4;
      end
      ST_TR_MC: begin
        cmd_o.sh_ld  = 1'b1;
        cmd_o.sh_sel = 3'd5;
      end
      ST_TR_N:  cmd_o.n_ld    = 1'b1;
      ST_TR_A1: cmd_o.nrd_sel = ADR_OLDER;
      ST_TR_W1: begin
        cmd_o.nrd_sel = ADR_OLDER;
        cmd_o.nwr_en  = 1'b1;
        cmd_o.nwr_sel = ADR_OLDER;
      end
      ST_TR_A2: cmd_o.nrd_sel = ADR_NEWER;
      ST_TR_W2: begin
        cmd_o.nrd_sel = ADR_NEWER;
        cmd_o.nwr_en  = 1'b1;
        cmd_o.nwr_sel = ADR_NEWER;
      end
      ST_TR_A3: cmd_o.nrd_sel = ADR_ITEM;
      ST_TR_W3: begin
        cmd_o.nwr_en = 1'b1;
        cmd_o.shift  = 1'b1;
      end
      ST_RD_A: cmd_o.nrd_sel = ADR_ITEM;
      ST_RD_W: cmd_o.out_ld  = sts_i.out_free;
      default: cmd_o.nrd_sel = ADR_ITEM;
    endcase
  end

endmodule

// File: src/msna_dp.sv
// ----------------------------------------------------------------------------
// msna_dp
// Datapath: item registers, shared 32x32 multiplier, point and normal
// memories, strip vertex registers, config register and output register.
// ----------------------------------------------------------------------------
module msna_dp import msna_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmd_t           cmd_i,
  output sts_t           sts_o,
  input  logic [AW-1:0]  in_index_i,
  input  logic [DW-1:0]  in_bx_i,
  input  logic [DW-1:0]  in_by_i,
  input  logic [DW-1:0]  in_bz_i,
  input  logic [DW-1:0]  in_ratio_i,
  input  logic           cfg_we_i,
  input  logic [SFW-1:0] cfg_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [AW-1:0]  out_index_o,
  output logic [DW-1:0]  out_x_o,
  output logic [DW-1:0]  out_y_o,
  output logic [DW-1:0]  out_z_o
);

  logic [SFW-1:0]    sf_q;
  logic [AW-1:0]     idx_q, older_q, newer_q, clr_q;
  logic [DW-1:0]     bx_q, by_q, bz_q, ratio_q, f_q;
  logic [DW-1:0]     ma, mb;
  logic signed [63:0] prod_q;
  logic [47:0]       sh_q [6];
  logic [3*DW-1:0]   p1_q, p2_q, p3_q, prdata_q, nrdata_q;
  logic [DW-1:0]     ax_q, ay_q, az_q, bxd_q, byd_q, bzd_q;
  logic [DW-1:0]     nx_q, ny_q, nz_q;
  logic [AW-1:0]     prd_addr, nrd_addr, nwr_addr;
  logic [3*DW-1:0]   pwdata, nwdata;
  logic [3*DW-1:0]   pmem [MAX_POINTS];
  logic [3*DW-1:0]   nmem [MAX_POINTS];
  logic              out_valid_q;
  logic [AW-1:0]     out_index_q;
  logic [3*DW-1:0]   out_data_q;

  function automatic logic [AW-1:0] pick(input addr_sel_e s, input logic [AW-1:0] it,
                                         input logic [AW-1:0] o, input logic [AW-1:0] n,
                                         input logic [AW-1:0] c);
    case (s)
      ADR_OLDER: pick = o;
      ADR_NEWER: pick = n;
      ADR_CLR:   pick = c;
      default:   pick = it;
    endcase
  endfunction

  function automatic logic [DW-1:0] diff(input logic [DW-1:0] a, input logic [DW-1:0] b);
    diff = sat32(ext49(a) - ext49(b));
  endfunction

  function automatic logic [DW-1:0] cross_n(input logic [47:0] p, input logic [47:0] q,
                                            input logic ng);
    logic [DW-1:0] t;
    t = sat32($signed({p[47], p}) - $signed({q[47], q}));
    cross_n = ng ? sat32(-ext49(t)) : t;
  endfunction

  // config register and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q        <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) sf_q <= cfg_data_i;
      if (cmd_i.set_older) older_q <= in_index_i;
      if (cmd_i.set_newer) newer_q <= in_index_i;
      if (cmd_i.shift) begin
        older_q <= newer_q;
        newer_q <= idx_q;
      end
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(MAX_POINTS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // multiplier operand select
  always_comb begin
    ma = ratio_q;
    mb = {{(DW-SFW){sf_q[SFW-1]}}, sf_q};
    case (cmd_i.mul_op)
      MUL_BX:   begin ma = bx_q; mb = f_q;   end
      MUL_BY:   begin ma = by_q; mb = f_q;   end
      MUL_BZ:   begin ma = bz_q; mb = f_q;   end
      MUL_AYBZ: begin ma = ay_q; mb = bzd_q; end
      MUL_AZBY: begin ma = az_q; mb = byd_q; end
      MUL_AZBX: begin ma = az_q; mb = bxd_q; end
      MUL_AXBZ: begin ma = ax_q; mb = bzd_q; end
      MUL_AXBY: begin ma = ax_q; mb = byd_q; end
      MUL_AYBX: begin ma = ay_q; mb = bxd_q; end
      default:  ma = ratio_q;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(ma) * $signed(mb);
    if (cmd_i.item_ld) begin
      idx_q   <= in_index_i;
      bx_q    <= in_bx_i;
      by_q    <= in_by_i;
      bz_q    <= in_bz_i;
      ratio_q <= in_ratio_i;
    end
    if (cmd_i.f_ld) f_q <= sat32($signed({prod_q[63], prod_q[63:16]}) + 49'sd65536);
    if (cmd_i.sh_ld) sh_q[cmd_i.sh_sel] <= prod_q[63:16];
    case (cmd_i.p_cap)
      PC_1:    p1_q <= prdata_q;
      PC_2:    p2_q <= prdata_q;
      PC_3:    p3_q <= prdata_q;
      default: p1_q <= p1_q;
    endcase
    if (cmd_i.diff_ld) begin
      ax_q  <= diff(p3_q[31:0],  p1_q[31:0]);
      ay_q  <= diff(p3_q[63:32], p1_q[63:32]);
      az_q  <= diff(p3_q[95:64], p1_q[95:64]);
      bxd_q <= diff(p2_q[31:0],  p1_q[31:0]);
      byd_q <= diff(p2_q[63:32], p1_q[63:32]);
      bzd_q <= diff(p2_q[95:64], p1_q[95:64]);
    end
    if (cmd_i.n_ld) begin
      nx_q <= cross_n(sh_q[0], sh_q[1], cmd_i.neg);
      ny_q <= cross_n(sh_q[2], sh_q[3], cmd_i.neg);
      nz_q <= cross_n(sh_q[4], sh_q[5], cmd_i.neg);
    end
    if (cmd_i.out_ld) begin
      out_index_q <= idx_q;
      out_data_q  <= nrdata_q;
    end
  end

  // memory addresses and write data
  always_comb begin
    prd_addr = pick(cmd_i.prd_sel, idx_q, older_q, newer_q, clr_q);
    nrd_addr = pick(cmd_i.nrd_sel, idx_q, older_q, newer_q, clr_q);
    nwr_addr = pick(cmd_i.nwr_sel, idx_q, older_q, newer_q, clr_q);
    pwdata   = {sat32($signed({sh_q[2][47], sh_q[2]})),
                sat32($signed({sh_q[1][47], sh_q[1]})),
                sat32($signed({sh_q[0][47], sh_q[0]}))};
    if (cmd_i.nwr_zero) begin
      nwdata = '0;
    end else begin
      nwdata = {sat32(ext49(nrdata_q[95:64]) + ext49(nz_q)),
                sat32(ext49(nrdata_q[63:32]) + ext49(ny_q)),
                sat32(ext49(nrdata_q[31:0])  + ext49(nx_q))};
    end
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.pwr_en) pmem[idx_q] <= pwdata;
    prdata_q <= pmem[prd_addr];
  end

  // normal memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.nwr_en) nmem[nwr_addr] <= nwdata;
    nrdata_q <= nmem[nrd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_x_o     = out_data_q[31:0];
  assign out_y_o     = out_data_q[63:32];
  assign out_z_o     = out_data_q[95:64];

endmodule

// File: src/morph_and_strip_normal_accumulate.sv
// ----------------------------------------------------------------------------
// morph_and_strip_normal_accumulate
// Morphing point store with triangle-strip vertex-normal accumulation.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry normal memory to zero, one
// entry a cycle, and takes no item until done. A read item may wait on the
// output register, and the first two indices of a strip only record their
// vertices. Each further strip index makes three point reads, six products on
// the one shared 32x32 multiplier, and three read-modify-write passes over
// the normal memory (one read and one write port). Config writes are taken
// in any cycle and must only be issued while the block is idle.
module morph_and_strip_normal_accumulate import msna_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // point_index[11:0], base_x[43:12], base_y[75:44], base_z[107:76],
  // scale_ratio[139:108], zero pad
  input  logic [143:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]     s_axis_tuser,
  input  logic           s_axis_tlast,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // normal_index[11:0], normal_x[43:12], normal_y[75:44], normal_z[107:76],
  // zero pad
  output logic [111:0]   m_axis_tdata,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [SFW-1:0] cfg_data_i
);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] oi;
  logic [DW-1:0] ox, oy, oz;

  assign cfg_ready_o = 1'b1;

  msna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msna_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_index_i  (s_axis_tdata[11:0]),
    .in_bx_i     (s_axis_tdata[43:12]),
    .in_by_i     (s_axis_tdata[75:44]),
    .in_bz_i     (s_axis_tdata[107:76]),
    .in_ratio_i  (s_axis_tdata[139:108]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (oi),
    .out_x_o     (ox),
    .out_y_o     (oy),
    .out_z_o     (oz)
  );

  assign m_axis_tdata = {4'b0, oz, oy, ox, oi};

`ifndef SYNTH
  // a finished result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output overrun");

  // a loaded result shows up on the next cycle
  a_out_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |=> m_axis_tvalid)
    else $error("result lost");

  // no item is taken while the normal memory is being written
  a_busy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.nwr_en |-> !s_axis_tready)
    else $error("item taken during normal write");
`endif

endmodule

// File: verif/tb_morph_and_strip_normal_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morph_and_strip_normal_accumulate
// Self-checking bench for the morph and strip normal accumulator. Loads
// points, walks triangle strips and reads back normals; every read is
// compared field by field against an in-bench model of the scaling, the
// cross products and the saturating accumulation.
// ----------------------------------------------------------------------------
module tb_morph_and_strip_normal_accumulate;
  import msna_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int N_RANDOM    = 630;

  typedef struct packed {
    logic [11:0] idx;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
  } normal_t;

  typedef struct {
    kind_e       kind;
    logic [11:0] idx;
    logic [31:0] bx, by, bz, ratio;
    logic        last;
    logic        chk;
    logic [31:0] ex, ey, ez;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [SFW-1:0] cfg_data_i = '0;

  morph_and_strip_normal_accumulate u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .s_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic signed [63:0] morph_scale;
  logic [31:0] px [MAX_POINTS], py [MAX_POINTS], pz [MAX_POINTS];
  logic [31:0] nrm_x [MAX_POINTS], nrm_y [MAX_POINTS], nrm_z [MAX_POINTS];
  bit          loaded [MAX_POINTS];
  logic [11:0] older_v, newer_v;
  int          phase;
  bit          odd_tri;

  normal_t normals_due [$];
  int      errors = 0;
  bit      calm = 1'b0;
  bit      hold_long = 1'b0;
  int      cycles = 0;

  function automatic logic signed [63:0] floor16(logic signed [63:0] v);
    return v >>> 16;
  endfunction

  function automatic logic [31:0] clamp(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sx(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] cross_term(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c, logic [31:0] d);
    return clamp(floor16(sx(a) * sx(b)) - floor16(sx(c) * sx(d)));
  endfunction

  task automatic accum(logic [11:0] i, logic [31:0] x, logic [31:0] y,
                       logic [31:0] z);
    nrm_x[i] = clamp(sx(nrm_x[i]) + sx(x));
    nrm_y[i] = clamp(sx(nrm_y[i]) + sx(y));
    nrm_z[i] = clamp(sx(nrm_z[i]) + sx(z));
  endtask

  task automatic add_triangle(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    logic [31:0] ax, ay, az, bx, by, bz, nx, ny, nz;
    ax = clamp(sx(px[c]) - sx(px[a]));
    ay = clamp(sx(py[c]) - sx(py[a]));
    az = clamp(sx(pz[c]) - sx(pz[a]));
    bx = clamp(sx(px[b]) - sx(px[a]));
    by = clamp(sx(py[b]) - sx(py[a]));
    bz = clamp(sx(pz[b]) - sx(pz[a]));
    nx = cross_term(ay, bz, az, by);
    ny = cross_term(az, bx, ax, bz);
    nz = cross_term(ax, by, ay, bx);
    if (!odd_tri) begin
      nx = clamp(-sx(nx));
      ny = clamp(-sx(ny));
      nz = clamp(-sx(nz));
    end
    accum(a, nx, ny, nz);
    accum(b, nx, ny, nz);
    accum(c, nx, ny, nz);
  endtask

  // advance the model by one accepted item, queue any normal it returns
  task automatic predict_item(row_t r);
    logic signed [63:0] f;
    normal_t n;
    case (r.kind)
      KIND_LOAD: begin
        f = sx(clamp(floor16(sx(r.ratio) * morph_scale) + ONE_Q16));
        px[r.idx] = clamp(floor16(sx(r.bx) * f));
        py[r.idx] = clamp(floor16(sx(r.by) * f));
        pz[r.idx] = clamp(floor16(sx(r.bz) * f));
        nrm_x[r.idx] = '0; nrm_y[r.idx] = '0; nrm_z[r.idx] = '0;
        loaded[r.idx] = 1'b1;
      end
      KIND_STRIP: begin
        if (phase == 0) begin
          older_v = r.idx; phase = 1;
        end else if (phase == 1) begin
          newer_v = r.idx; phase = 2; odd_tri = 1'b0;
        end else begin
          add_triangle(older_v, newer_v, r.idx);
          older_v = newer_v; newer_v = r.idx; odd_tri = !odd_tri;
        end
        if (r.last) begin
          phase = 0; odd_tri = 1'b0;
        end
      end
      KIND_READ: begin
        n = '{r.idx, nrm_x[r.idx], nrm_y[r.idx], nrm_z[r.idx]};
        if (r.chk && {r.ex, r.ey, r.ez} != {n.nx, n.ny, n.nz}) begin
          $display("%0t table row for %0d: expected %h %h %h, model %h %h %h",
                   $time, r.idx, r.ex, r.ey, r.ez, n.nx, n.ny, n.nz);
          errors++;
        end
        normals_due.push_back(n);
      end
      default: ;
    endcase
  endtask

  // random gap on the input side, valid dropped for its length
  task automatic idle_burst();
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  // valid stays high after acceptance; the next send or a drain replaces it
  task automatic send(row_t r);
    idle_burst();
    s_axis_tdata  <= {4'd0, r.ratio, r.bz, r.by, r.bx, r.idx};
    s_axis_tuser  <= r.kind;
    s_axis_tlast  <= r.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(r);
    @(negedge clk_i);
  endtask

  task automatic write_scale(logic [SFW-1:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    morph_scale = {{43{v[SFW-1]}}, v};
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (normals_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic row_t mk(kind_e k, logic [11:0] i, logic l = 1'b0);
    row_t r;
    r.kind = k; r.idx = i; r.last = l;
    r.bx = $urandom; r.by = $urandom; r.bz = $urandom; r.ratio = $urandom;
    r.chk = 1'b0; r.ex = '0; r.ey = '0; r.ez = '0;
    return r;
  endfunction

  function automatic row_t ld(logic [11:0] i, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [31:0] q);
    row_t r;
    r = mk(KIND_LOAD, i);
    r.bx = x; r.by = y; r.bz = z; r.ratio = q;
    return r;
  endfunction

  function automatic row_t rd_exp(logic [11:0] i, logic [31:0] x,
                                  logic [31:0] y, logic [31:0] z);
    row_t r;
    r = mk(KIND_READ, i);
    r.chk = 1'b1; r.ex = x; r.ey = y; r.ez = z;
    return r;
  endfunction

  // random strip-heavy traffic over a small pool of loaded points
  function automatic row_t rand_item(ref int strip_left);
    logic [11:0] i;
    int p;
    p = $urandom_range(0, 99);
    i = $urandom_range(0, 99) < 10 ? 12'($urandom_range(4000, 4095))
                                   : 12'($urandom_range(0, 31));
    if (strip_left > 0 && p < 70) begin
      do i = $urandom_range(0, 99) < 10 ? 12'($urandom_range(4000, 4095))
                                        : 12'($urandom_range(0, 31));
      while (!loaded[i]);
      strip_left--;
      return mk(KIND_STRIP, i, strip_left == 0);
    end
    if (strip_left == 0 && p < 50) strip_left = $urandom_range(1, 8);
    if (p < 80) return mk(KIND_READ, i);
    if (p < 95) begin
      if ($urandom_range(0, 3) == 0) return mk(KIND_LOAD, i);
      return ld(i, $urandom_range(0, 32'h7FFFFF) - 32'h400000,
                $urandom_range(0, 32'h7FFFFF) - 32'h400000,
                $urandom_range(0, 32'h7FFFFF) - 32'h400000,
                $urandom_range(0, 32'h3FFFF) - 32'h20000);
    end
    return mk(kind_e'(2'd3), i);
  endfunction

  // output side: random stalls, one long hold-off on request
  initial begin
    int k;
    normal_t got, want;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        for (k = 0; k < 600; k++) @(negedge clk_i);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx = m_axis_tdata[11:0];
        got.nx  = m_axis_tdata[43:12];
        got.ny  = m_axis_tdata[75:44];
        got.nz  = m_axis_tdata[107:76];
        if (normals_due.size() == 0) begin
          $display("%0t unexpected normal: expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = normals_due.pop_front();
          if (got.idx !== want.idx) begin
            $display("%0t normal_index: expected %h, actual %h", $time, want.idx, got.idx);
            errors++;
          end
          if (got.nx !== want.nx) begin
            $display("%0t normal_x: expected %h, actual %h", $time, want.nx, got.nx);
            errors++;
          end
          if (got.ny !== want.ny) begin
            $display("%0t normal_y: expected %h, actual %h", $time, want.ny, got.ny);
            errors++;
          end
          if (got.nz !== want.nz) begin
            $display("%0t normal_z: expected %h, actual %h", $time, want.nz, got.nz);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t tbl [$];
    int j, strip_left;
    logic [SFW-1:0] scales [4];
    morph_scale = 0; phase = 0; odd_tri = 1'b0; older_v = '0; newer_v = '0;
    foreach (px[i]) begin
      px[i] = '0; py[i] = '0; pz[i] = '0;
      nrm_x[i] = '0; nrm_y[i] = '0; nrm_z[i] = '0; loaded[i] = 1'b0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table: extremes, short strips, repeats, wrapping indices
    tbl.push_back(rd_exp(12'd0, '0, '0, '0));
    tbl.push_back(rd_exp(12'hFFF, '0, '0, '0));
    tbl.push_back(ld(12'd0, 32'h0, 32'h0, 32'h0, 32'h0));
    tbl.push_back(ld(12'd1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
    tbl.push_back(ld(12'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000));
    tbl.push_back(ld(12'hFFF, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0));
    tbl.push_back(rd_exp(12'd1, '0, '0, '0));
    tbl.push_back(mk(KIND_STRIP, 12'd0, 1'b1));
    tbl.push_back(mk(KIND_STRIP, 12'd1));
    tbl.push_back(mk(KIND_STRIP, 12'd2, 1'b1));
    tbl.push_back(mk(KIND_STRIP, 12'd0));
    tbl.push_back(mk(KIND_STRIP, 12'd1));
    tbl.push_back(mk(KIND_READ, 12'd1));
    tbl.push_back(ld(12'd3, 32'h0, 32'h0003_0000, 32'h0, 32'h0001_0000));
    tbl.push_back(mk(KIND_STRIP, 12'd2));
    tbl.push_back(mk(KIND_STRIP, 12'hFFF));
    tbl.push_back(mk(KIND_STRIP, 12'hFFF, 1'b1));
    tbl.push_back(mk(kind_e'(2'd3), 12'd5, 1'b1));
    tbl.push_back(mk(KIND_READ, 12'd0));
    tbl.push_back(mk(KIND_READ, 12'd2));
    tbl.push_back(mk(KIND_READ, 12'hFFF));
    tbl.push_back(mk(KIND_READ, 12'd3));
    foreach (tbl[i]) send(tbl[i]);
    drain();

    scales[0] = 21'd557056;                        // 557056, i.e. 8.5 with 16 fraction bits
    scales[1] = 21'h1D8000;                        // -163840
    scales[2] = 21'h008000;
    scales[3] = 21'd0;
    for (j = 0; j < N_RANDOM; j++) begin
      if (j % 160 == 0) begin
        // close any open strip before a config write
        if (phase != 0) send(mk(KIND_STRIP, older_v, 1'b1));
        drain();
        write_scale(scales[j / 160]);
        strip_left = 0;
      end
      if (j == 200) hold_long = 1'b1;
      if (j == N_RANDOM - 60) calm = 1'b1;
      send(rand_item(strip_left));
    end
    if (phase != 0) send(mk(KIND_STRIP, older_v, 1'b1));
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
